/* rtl/core/dct_coefficient_stego_extractor_core_defines.svh */
// Assertion macros shared by the stego extractor core
`ifndef DCT_COEFFICIENT_STEGO_EXTRACTOR_CORE_DEFINES_SVH
`define DCT_COEFFICIENT_STEGO_EXTRACTOR_CORE_DEFINES_SVH

// Check that cond implies prop in the same cycle
`define DCSE_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("dcse assertion failed");

// Check that cond implies prop in the next cycle
`define DCSE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("dcse assertion failed");

`endif

/* rtl/core/dcse_pkg.sv */
// Shared types, constants and helpers of the stego extractor core
package dcse_pkg;

    localparam int COUNT_WIDTH = 18;
    localparam int SUM_WIDTH   = 19;
    localparam int TARGET_W    = SUM_WIDTH + 2;
    localparam int CMP_W       = (COUNT_WIDTH > TARGET_W) ? COUNT_WIDTH : TARGET_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CFG_HEADER_THR = 1'b0;
    localparam logic CFG_DATA_THR   = 1'b1;

    localparam logic [2:0] PH_EXP   = 3'd0;
    localparam logic [2:0] PH_BITS  = 3'd1;
    localparam logic [2:0] PH_CLOSE = 3'd2;
    localparam logic [2:0] PH_STUCK = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    typedef struct packed {
        logic       hdr;
        logic       dat;
        logic       img_end;
        logic [3:0] mag_low;
    } coef_item_t;

    function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [1:0] n);
        logic [7:0] r;
        case (n)
            2'd1:    r = {p[1:0], 6'b0};
            2'd2:    r = {p[3:0], 4'b0};
            2'd3:    r = {p, 2'b0};
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/dcse_front.sv */
// Front end: magnitude and header/data qualification of each coefficient
module dcse_front
    import dcse_pkg::*;
(
    input  logic signed [11:0] coef_value,
    input  logic [5:0]         coef_position,
    input  logic               image_end,
    input  logic [10:0]        header_thr,
    input  logic [10:0]        data_thr,
    output coef_item_t         item
);

    logic [11:0] mag;
    logic        ac;

    assign mag = coef_value[11] ? (~coef_value + 12'd1) : coef_value;
    assign ac  = (coef_position != 6'd0);

    always_comb
    begin
        item.hdr     = ac && (mag > {1'b0, header_thr});
        item.dat     = ac && (mag > 12'd1) && (mag >= {1'b0, data_thr});
        item.img_end = image_end;
        item.mag_low = mag[3:0];
    end

endmodule

/* rtl/core/dcse_queue.sv */
// Short item queue between the front and back ends
module dcse_queue
    import dcse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  coef_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output coef_item_t pop_item
);

    coef_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/dcse_back.sv */
// Back end: header/data state machine, symbol packing and output register
module dcse_back
    import dcse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  coef_item_t item,
    output logic       pop,
    output logic       msg_valid,
    input  logic       msg_stall,
    output logic [7:0] message_byte,
    output logic       message_last
);

`include "dct_coefficient_stego_extractor_core_defines.svh"

    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    logic [2:0]             phase_reg, phase_next;
    logic [3:0]             exp_reg, exp_next;
    logic [SUM_WIDTH-1:0]   sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [5:0]             partial_reg, partial_next;
    logic [1:0]             nsym_reg, nsym_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             byte_reg;
    logic                   last_reg;

    logic                   emit;
    logic [7:0]             byte_val;
    logic                   last_val;
    logic [1:0]             sym;
    logic [CMP_W-1:0]       target;

    assign pop          = q_not_empty && (!out_valid_reg || !msg_stall);
    assign msg_valid    = out_valid_reg;
    assign message_byte = byte_reg;
    assign message_last = last_reg;
    assign sym          = item.mag_low[1:0];
    assign target       = CMP_W'({sum_reg, 2'b00});

    always_comb
    begin
        phase_next   = phase_reg;
        exp_next     = exp_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        partial_next = partial_reg;
        nsym_next    = nsym_reg;
        emit         = 1'b0;
        byte_val     = 8'h00;
        last_val     = 1'b0;
        case (phase_reg)
            PH_EXP:
            begin
                if (item.hdr)
                begin
                    exp_next   = item.mag_low;
                    phase_next = PH_BITS;
                end
            end
            PH_BITS:
            begin
                if (item.hdr)
                begin
                    if (item.mag_low[0])
                    begin
                        sum_next = sum_reg + (SUM_WIDTH'(1) << exp_reg);
                    end
                    if (exp_reg == 4'd0)
                    begin
                        phase_next = PH_STUCK;
                    end
                    else
                    begin
                        exp_next = exp_reg - 4'd1;
                        if (exp_reg == 4'd1)
                        begin
                            phase_next = PH_CLOSE;
                        end
                    end
                end
            end
            PH_CLOSE:
            begin
                if (item.hdr)
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (item.dat)
                begin
                    cnt_next = (cnt_reg != CMAX) ? cnt_reg + 1'b1 : cnt_reg;
                    if (nsym_reg == 2'd3)
                    begin
                        emit         = 1'b1;
                        byte_val     = {partial_reg, sym};
                        partial_next = '0;
                        nsym_next    = '0;
                    end
                    else
                    begin
                        partial_next = {partial_reg[3:0], sym};
                        nsym_next    = nsym_reg + 2'd1;
                    end
                    if (CMP_W'(cnt_next) == target)
                    begin
                        phase_next = PH_DONE;
                        if (!emit && nsym_next != 2'd0)
                        begin
                            emit     = 1'b1;
                            byte_val = pad_byte(partial_next, nsym_next);
                        end
                        last_val     = 1'b1;
                        partial_next = '0;
                        nsym_next    = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (item.img_end)
        begin
            if (!emit && nsym_next != 2'd0)
            begin
                emit     = 1'b1;
                byte_val = pad_byte(partial_next, nsym_next);
            end
            last_val     = 1'b1;
            phase_next   = PH_EXP;
            exp_next     = '0;
            sum_next     = '0;
            cnt_next     = '0;
            partial_next = '0;
            nsym_next    = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (!msg_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_EXP;
            exp_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            partial_reg   <= '0;
            nsym_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg   <= phase_next;
                exp_reg     <= exp_next;
                sum_reg     <= sum_next;
                cnt_reg     <= cnt_next;
                partial_reg <= partial_next;
                nsym_reg    <= nsym_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            byte_reg <= byte_val;
            last_reg <= last_val;
        end
    end

    `DCSE_ASSERT_SAME(a_pop_slot_free, clk, rst_n, pop, (!out_valid_reg || !msg_stall))
    `DCSE_ASSERT_SAME(a_no_pending_outside_data, clk, rst_n, (phase_reg != PH_DATA), (nsym_reg == 2'd0 && partial_reg == 6'd0))
    `DCSE_ASSERT_NEXT(a_image_end_clears, clk, rst_n, (pop && item.img_end), (phase_reg == PH_EXP && sum_reg == '0 && cnt_reg == '0))

endmodule

/* rtl/core/dct_coefficient_stego_extractor_core.sv */
// Top level of the DCT coefficient stego extractor core
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  coef    | coef_valid, coef_stall, coef_value,            | in
//          | coef_position, image_end                       |
//  msg     | msg_valid, msg_stall, message_byte,            | out
//          | message_last                                   |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// One coefficient in and one queued item retired per cycle, each while its stall is low.
// An accepted coefficient is written into the item queue, then its byte into the output register.
// coef_stall rises only when the four-entry item queue is full.
// msg_stall holds the output register and, once the queue fills, backs up into coef.
// rst_n clears the queue and the decoder state and sets the thresholds to 15 and 4 at once.
module dct_coefficient_stego_extractor_core
    import dcse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               coef_valid,
    output logic               coef_stall,
    input  logic signed [11:0] coef_value,
    input  logic [5:0]         coef_position,
    input  logic               image_end,
    output logic               msg_valid,
    input  logic               msg_stall,
    output logic [7:0]         message_byte,
    output logic               message_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [10:0]        cfg_data
);

    logic [10:0] header_thr_reg;
    logic [10:0] data_thr_reg;
    coef_item_t  front_item;
    coef_item_t  back_item;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;
    logic        q_push;

    assign cfg_ready  = 1'b1;
    assign coef_stall = q_full;
    assign q_push     = coef_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_thr_reg <= 11'd15;
            data_thr_reg   <= 11'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER_THR: header_thr_reg <= cfg_data;
                CFG_DATA_THR:   data_thr_reg   <= cfg_data;
                default:        header_thr_reg <= header_thr_reg;
            endcase
        end
    end

    dcse_front u_front (
        .coef_value    (coef_value),
        .coef_position (coef_position),
        .image_end     (image_end),
        .header_thr    (header_thr_reg),
        .data_thr      (data_thr_reg),
        .item          (front_item)
    );

    dcse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (back_item)
    );

    dcse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .item         (back_item),
        .pop          (q_pop),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .message_byte (message_byte),
        .message_last (message_last)
    );

endmodule
